>>> rtl/gwl_pkg.sv
// ----------------------------------------------------------------------------
// gwl_pkg: shared types and constants of the G-code word lexer
// Result record, result kinds, character codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package gwl_pkg;

  // Default sizes
  localparam int MAX_DIGITS_DEF  = 18;
  localparam int LINE_LENGTH_DEF = 4096;

  // Fixed field widths
  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 2;
  localparam int LETTER_W = 5;
  localparam int ACCUM_W  = 60;
  localparam int MANT_W   = 61;
  localparam int COUNT_W  = 5;
  localparam int OFFSET_W = 12;

  // Packed stream widths
  localparam int TDATA_FIELDS_W = LETTER_W + MANT_W + COUNT_W + OFFSET_W;
  localparam int TDATA_W        = ((TDATA_FIELDS_W + 7) / 8) * 8;

  // Result queue depth
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_WORD       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_LETTER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_VALUE  = 2'd3;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_GAP   = 8'h20;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [LETTER_W-1:0]      word_letter;
    logic signed [MANT_W-1:0] mantissa;
    logic [COUNT_W-1:0]       frac_digits;
    logic [OFFSET_W-1:0]      start_offset;
    logic                     last;
  } res_t;

  // Up to two results caused by one character, slot a first
  typedef struct packed {
    logic a_valid;
    logic b_valid;
    res_t a;
    res_t b;
  } res_pair_t;

endpackage

`default_nettype wire

>>> rtl/gwl_lexer.sv
// ----------------------------------------------------------------------------
// gwl_lexer: per-character lexer step
// Holds the line state and turns one character into zero, one or two results.
// ----------------------------------------------------------------------------
`default_nettype none

module gwl_lexer #(
  parameter int MAX_DIGITS  = gwl_pkg::MAX_DIGITS_DEF,
  parameter int LINE_LENGTH = gwl_pkg::LINE_LENGTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        char_valid,
  input  wire logic [gwl_pkg::CHAR_W-1:0]  char_code,
  output gwl_pkg::res_pair_t               push
);

  import gwl_pkg::*;

  localparam int OFFSET_LIMIT = (LINE_LENGTH - 1 < 4095) ? LINE_LENGTH - 1 : 4095;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = OFFSET_W'(OFFSET_LIMIT);
  localparam logic [COUNT_W-1:0]  DIGIT_MAX  = COUNT_W'(MAX_DIGITS);

  typedef enum logic [2:0] {
    PH_SEEK_LETTER,
    PH_COMMENT_LETTER,
    PH_SEEK_VALUE,
    PH_COMMENT_VALUE,
    PH_INT,
    PH_FRAC,
    PH_IGNORE
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [LETTER_W-1:0]   letter_r, letter_nxt;
  logic [ACCUM_W-1:0]    accum_r, accum_nxt;
  logic                  neg_r, neg_nxt;
  logic [COUNT_W-1:0]    dcount_r, dcount_nxt;
  logic [COUNT_W-1:0]    fcount_r, fcount_nxt;
  logic [OFFSET_W-1:0]   offset_r, offset_nxt;
  logic [OFFSET_W-1:0]   wstart_r, wstart_nxt;

  // Character classes
  logic                is_ws, is_digit, is_letter, is_stop_end;
  logic [CHAR_W-1:0]   upper;
  logic [3:0]          digit;
  logic [ACCUM_W-1:0]  accum_x10;
  logic [MANT_W-1:0]   accum_ext;

  // Letter search outcome for the current character
  logic                sl_stop;
  logic [KIND_W-1:0]   sl_kind;
  phase_t              sl_phase;
  logic                sl_load;

  res_t                word_res;

  always_comb begin
    is_ws       = (char_code == CH_SPACE) || (char_code == CH_TAB);
    is_digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_stop_end = (char_code == CH_NUL) || (char_code == CH_PERCENT);
    upper       = ((char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z)) ?
                  char_code - CASE_GAP : char_code;
    is_letter   = (upper >= CH_UPPER_A) && (upper <= CH_UPPER_Z);
    digit       = 4'(char_code - CH_ZERO);
    // Multiply by ten as two shifts and one add
    accum_x10   = {accum_r[ACCUM_W-4:0], 3'b000} + {accum_r[ACCUM_W-2:0], 1'b0};
    accum_ext   = {1'b0, accum_r};

    sl_stop  = 1'b0;
    sl_kind  = KIND_END;
    sl_phase = PH_SEEK_LETTER;
    sl_load  = 1'b0;
    if (is_ws) begin
      sl_phase = PH_SEEK_LETTER;
    end else if (char_code == CH_LPAREN) begin
      sl_phase = PH_COMMENT_LETTER;
    end else if (is_stop_end) begin
      sl_stop  = 1'b1;
      sl_kind  = KIND_END;
      sl_phase = PH_IGNORE;
    end else if (is_letter) begin
      sl_load  = 1'b1;
      sl_phase = PH_SEEK_VALUE;
    end else begin
      sl_stop  = 1'b1;
      sl_kind  = KIND_BAD_LETTER;
      sl_phase = PH_IGNORE;
    end

    word_res.kind         = KIND_WORD;
    word_res.word_letter  = letter_r;
    word_res.mantissa     = neg_r ? -accum_ext : accum_ext;
    word_res.frac_digits  = fcount_r;
    word_res.start_offset = wstart_r;
    word_res.last         = 1'b0;
  end

  function automatic res_t stop_res(logic [KIND_W-1:0] kind, logic [OFFSET_W-1:0] start);
    res_t r;
    r.kind         = kind;
    r.word_letter  = '0;
    r.mantissa     = '0;
    r.frac_digits  = '0;
    r.start_offset = start;
    r.last         = 1'b1;
    return r;
  endfunction

  always_comb begin
    phase_nxt  = phase_r;
    letter_nxt = letter_r;
    accum_nxt  = accum_r;
    neg_nxt    = neg_r;
    dcount_nxt = dcount_r;
    fcount_nxt = fcount_r;
    offset_nxt = offset_r;
    wstart_nxt = wstart_r;
    push.a_valid = 1'b0;
    push.b_valid = 1'b0;
    push.a       = stop_res(KIND_END, wstart_r);
    push.b       = stop_res(KIND_END, wstart_r);

    unique case (phase_r)
      PH_SEEK_LETTER: begin
        phase_nxt = sl_phase;
        if (sl_stop) begin
          push.a_valid = 1'b1;
          push.a       = stop_res(sl_kind, wstart_r);
        end
        if (sl_load) begin
          letter_nxt = LETTER_W'(upper - CH_UPPER_A);
          accum_nxt  = '0;
          neg_nxt    = 1'b0;
          dcount_nxt = '0;
          fcount_nxt = '0;
        end
      end
      PH_COMMENT_LETTER: begin
        if (char_code == CH_RPAREN) begin
          phase_nxt = PH_SEEK_LETTER;
        end else if (char_code == CH_NUL) begin
          phase_nxt    = PH_IGNORE;
          push.a_valid = 1'b1;
          push.a       = stop_res(KIND_END, wstart_r);
        end
      end
      PH_SEEK_VALUE: begin
        if (is_ws) begin
          phase_nxt = PH_SEEK_VALUE;
        end else if (char_code == CH_LPAREN) begin
          phase_nxt = PH_COMMENT_VALUE;
        end else if (char_code == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_INT;
        end else if (char_code == CH_PLUS) begin
          phase_nxt = PH_INT;
        end else if (is_digit) begin
          accum_nxt  = ACCUM_W'(digit);
          dcount_nxt = COUNT_W'(1);
          phase_nxt  = PH_INT;
        end else if (char_code == CH_POINT) begin
          phase_nxt = PH_FRAC;
        end else begin
          phase_nxt    = PH_IGNORE;
          push.a_valid = 1'b1;
          push.a       = stop_res(KIND_BAD_VALUE, wstart_r);
        end
      end
      PH_COMMENT_VALUE: begin
        if (char_code == CH_RPAREN) begin
          phase_nxt = PH_SEEK_VALUE;
        end else if (char_code == CH_NUL) begin
          phase_nxt    = PH_IGNORE;
          push.a_valid = 1'b1;
          push.a       = stop_res(KIND_BAD_VALUE, wstart_r);
        end
      end
      PH_INT, PH_FRAC: begin
        if (is_digit) begin
          if (dcount_r >= DIGIT_MAX) begin
            phase_nxt    = PH_IGNORE;
            push.a_valid = 1'b1;
            push.a       = stop_res(KIND_BAD_VALUE, wstart_r);
          end else begin
            accum_nxt  = accum_x10 + ACCUM_W'(digit);
            dcount_nxt = dcount_r + COUNT_W'(1);
            if (phase_r == PH_FRAC) begin
              fcount_nxt = fcount_r + COUNT_W'(1);
            end
          end
        end else if ((char_code == CH_POINT) && (phase_r == PH_INT)) begin
          phase_nxt = PH_FRAC;
        end else begin
          // Close the word, then treat this character as a new letter search
          push.a_valid = 1'b1;
          push.a       = word_res;
          wstart_nxt   = offset_r;
          phase_nxt    = sl_phase;
          if (sl_stop) begin
            push.b_valid = 1'b1;
            push.b       = stop_res(sl_kind, offset_r);
          end
          if (sl_load) begin
            letter_nxt = LETTER_W'(upper - CH_UPPER_A);
            accum_nxt  = '0;
            neg_nxt    = 1'b0;
            dcount_nxt = '0;
            fcount_nxt = '0;
          end
        end
      end
      PH_IGNORE: begin
        phase_nxt = PH_IGNORE;
      end
      default: begin
        phase_nxt = PH_IGNORE;
      end
    endcase

    if (char_code == CH_NUL) begin
      phase_nxt  = PH_SEEK_LETTER;
      letter_nxt = '0;
      accum_nxt  = '0;
      neg_nxt    = 1'b0;
      dcount_nxt = '0;
      fcount_nxt = '0;
      offset_nxt = '0;
      wstart_nxt = '0;
    end else if (offset_r < OFFSET_MAX) begin
      offset_nxt = offset_r + OFFSET_W'(1);
    end

    if (!char_valid) begin
      push.a_valid = 1'b0;
      push.b_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEEK_LETTER;
      letter_r <= '0;
      accum_r  <= '0;
      neg_r    <= 1'b0;
      dcount_r <= '0;
      fcount_r <= '0;
      offset_r <= '0;
      wstart_r <= '0;
    end else if (char_valid) begin
      phase_r  <= phase_nxt;
      letter_r <= letter_nxt;
      accum_r  <= accum_nxt;
      neg_r    <= neg_nxt;
      dcount_r <= dcount_nxt;
      fcount_r <= fcount_nxt;
      offset_r <= offset_nxt;
      wstart_r <= wstart_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gwl_res_fifo.sv
// ----------------------------------------------------------------------------
// gwl_res_fifo: result queue
// Takes up to two results a cycle in order and hands out one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module gwl_res_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gwl_pkg::res_pair_t  push,
  output logic                     room2,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output gwl_pkg::res_t            res
);

  import gwl_pkg::*;

  res_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] count_r, count_nxt;
  logic                 pop;
  logic [1:0]           n_push;
  logic [RES_PTR_W-1:0] wr_ptr_b;

  always_comb begin
    pop        = res_valid && res_ready;
    n_push     = 2'(push.a_valid) + 2'(push.b_valid);
    wr_ptr_b   = wr_ptr_r + RES_PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(n_push);
    rd_ptr_nxt = pop ? rd_ptr_r + RES_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + RES_CNT_W'(n_push) - RES_CNT_W'(pop);
    res_valid  = (count_r != '0);
    room2      = (count_r <= RES_CNT_W'(RES_DEPTH - 2));
    res        = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      mem_r[wr_ptr_r] <= push.a;
    end
    if (push.b_valid) begin
      mem_r[wr_ptr_b] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gcode_word_lexer_core.sv
// ----------------------------------------------------------------------------
// gcode_word_lexer_core: streaming G-code word lexer
// Splits one line, a character per transaction, into letter/value words and
// a final end or error result.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                  | tuser | tlast
//  --------+-----+------------------------+-------+---------------------------
//  in_     | in  | char_code (0 ends line)| -     | -
//  out_    | out | letter, mantissa,      | kind  | final result of the line
//          |     | frac_digits, offset    |       |
//
// One character per cycle while in_tready is high: each transaction updates the
// registered line state; a multiply-by-ten add plus compares is the longest path.
// A character can produce a word and an end/error result together; both go
// into a four-entry result queue, and in_tready is high while two slots are free.
// Synchronous active-low reset returns the lexer to the letter search at offset
// zero and empties the queue. A stalled output fills the queue and then holds
// in_tready low; no result is ever dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module gcode_word_lexer_core #(
  parameter int MAX_DIGITS  = gwl_pkg::MAX_DIGITS_DEF,
  parameter int LINE_LENGTH = gwl_pkg::LINE_LENGTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input characters
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [gwl_pkg::CHAR_W-1:0]    in_tdata,   // [7:0] char_code
  // Results
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [4:0] word_letter, [65:5] mantissa, [70:66] frac_digits,
  // [82:71] start_offset, [87:83] zero
  output logic [gwl_pkg::TDATA_W-1:0]        out_tdata,
  output logic [gwl_pkg::KIND_W-1:0]         out_tuser,  // [1:0] kind
  output logic                               out_tlast
);

  import gwl_pkg::*;

  res_pair_t push;
  res_t      head;
  logic      room2;
  logic      in_xfer;

  // Advance the lexer only on an accepted transaction
  assign in_xfer = in_tvalid && in_tready;
  assign in_tready = room2;

  gwl_lexer #(
    .MAX_DIGITS  (MAX_DIGITS),
    .LINE_LENGTH (LINE_LENGTH)
  ) u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (in_xfer),
    .char_code  (in_tdata),
    .push       (push)
  );

  gwl_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (head)
  );

  // Pack the result; pad the upper bits of tdata with zeros
  assign out_tdata = TDATA_W'({head.start_offset, head.frac_digits,
                               head.mantissa, head.word_letter});
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

`default_nettype wire

>>> tb/tb_gcode_word_lexer_core.sv
// ----------------------------------------------------------------------------
// tb_gcode_word_lexer_core: self-checking bench for the G-code word lexer
// Streams directed and random G-code lines into the core, one character per
// transaction. A behavioral lexer in the bench predicts each word, end and
// error result, and every output transaction is checked in order against it.
// Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_gcode_word_lexer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gwl_pkg::*;

  localparam int OFFSET_CAP   = (LINE_LENGTH_DEF - 1 < 4095) ? LINE_LENGTH_DEF - 1 : 4095;
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transaction
  localparam int TAIL_CYCLES  = 16;
  localparam int RANDOM_CHARS = 800;

  // Lexer phases of the prediction
  typedef enum logic [2:0] {
    SEEK_LETTER, LETTER_COMMENT, SEEK_VALUE, VALUE_COMMENT,
    INT_DIGITS, FRAC_DIGITS, SKIP_REST
  } lex_phase_t;

  // One pending character; drain_first holds it back until no result is due
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              drain_first;
  } char_item_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [CHAR_W-1:0]   in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic [KIND_W-1:0]   out_tuser;
  logic                out_tlast;

  gcode_word_lexer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  char_item_t char_queue[$];
  res_t       expected_results[$];
  bit         hold_next;

  // Lexer state of the prediction
  lex_phase_t            lex_phase    = SEEK_LETTER;
  logic [LETTER_W-1:0]   cur_letter   = '0;
  logic [ACCUM_W-1:0]    digit_value  = '0;
  logic                  minus_seen   = 1'b0;
  logic [COUNT_W-1:0]    digits_seen  = '0;
  logic [COUNT_W-1:0]    frac_seen    = '0;
  logic [OFFSET_W-1:0]   line_pos     = '0;
  logic [OFFSET_W-1:0]   search_start = '0;

  int         mismatch_count;
  int         quiet_cycles;
  int         send_gap;
  int         take_gap;
  bit         send_calm;
  bit         take_calm;
  char_item_t next_char;
  res_t       got;
  res_t       want;

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void push_result(logic [KIND_W-1:0] kind, logic [LETTER_W-1:0] letter,
                                      logic [MANT_W-1:0] mant, logic [COUNT_W-1:0] frac,
                                      logic last);
    res_t r;
    r.kind         = kind;
    r.word_letter  = letter;
    r.mantissa     = mant;
    r.frac_digits  = frac;
    r.start_offset = search_start;
    r.last         = last;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // End or error: final result, then drop the rest of the line
  function automatic void close_line(logic [KIND_W-1:0] kind);
    push_result(kind, '0, '0, '0, 1'b1);
    lex_phase = SKIP_REST;
  endfunction

  function automatic void look_for_letter(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] up;
    up = c;
    if (c == CH_LPAREN) begin
      lex_phase = LETTER_COMMENT;
    end else if (c == CH_NUL || c == CH_PERCENT) begin
      close_line(KIND_END);
    end else if (c != CH_SPACE && c != CH_TAB) begin
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) up = c - CASE_GAP;
      if (up < CH_UPPER_A || up > CH_UPPER_Z) begin
        close_line(KIND_BAD_LETTER);
      end else begin
        cur_letter  = LETTER_W'(up - CH_UPPER_A);
        digit_value = '0;
        minus_seen  = 1'b0;
        digits_seen = '0;
        frac_seen   = '0;
        lex_phase   = SEEK_VALUE;
      end
    end
  endfunction

  function automatic void look_for_value(logic [CHAR_W-1:0] c);
    if (c == CH_LPAREN) begin
      lex_phase = VALUE_COMMENT;
    end else if (c == CH_MINUS) begin
      minus_seen = 1'b1;
      lex_phase  = INT_DIGITS;
    end else if (c == CH_PLUS) begin
      lex_phase = INT_DIGITS;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      digit_value = ACCUM_W'(c - CH_ZERO);
      digits_seen = COUNT_W'(1);
      lex_phase   = INT_DIGITS;
    end else if (c == CH_POINT) begin
      lex_phase = FRAC_DIGITS;
    end else if (c != CH_SPACE && c != CH_TAB) begin
      close_line(KIND_BAD_VALUE);
    end
  endfunction

  // Advance the lexer by one accepted character
  function automatic void lex_char(logic [CHAR_W-1:0] c);
    logic [MANT_W-1:0] mant;
    case (lex_phase)
      SEEK_LETTER: look_for_letter(c);
      LETTER_COMMENT: begin
        if (c == CH_RPAREN) lex_phase = SEEK_LETTER;
        else if (c == CH_NUL) close_line(KIND_END);
      end
      SEEK_VALUE: look_for_value(c);
      VALUE_COMMENT: begin
        if (c == CH_RPAREN) lex_phase = SEEK_VALUE;
        else if (c == CH_NUL) close_line(KIND_BAD_VALUE);
      end
      INT_DIGITS, FRAC_DIGITS: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (digits_seen >= MAX_DIGITS_DEF) begin
            close_line(KIND_BAD_VALUE);
          end else begin
            digit_value = digit_value * ACCUM_W'(10) + ACCUM_W'(c - CH_ZERO);
            digits_seen++;
            if (lex_phase == FRAC_DIGITS) frac_seen++;
          end
        end else if (c == CH_POINT && lex_phase == INT_DIGITS) begin
          lex_phase = FRAC_DIGITS;
        end else begin
          // The terminating character also starts the next letter search
          mant = {1'b0, digit_value};
          if (minus_seen) mant = -mant;
          push_result(KIND_WORD, cur_letter, mant, frac_seen, 1'b0);
          search_start = line_pos;
          lex_phase    = SEEK_LETTER;
          look_for_letter(c);
        end
      end
      default: ;
    endcase

    if (c == CH_NUL) begin
      lex_phase    = SEEK_LETTER;
      cur_letter   = '0;
      digit_value  = '0;
      minus_seen   = 1'b0;
      digits_seen  = '0;
      frac_seen    = '0;
      line_pos     = '0;
      search_start = '0;
    end else if (line_pos < OFFSET_CAP) begin
      line_pos++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic void queue_char(logic [CHAR_W-1:0] c);
    char_item_t entry;
    entry.code        = c;
    entry.drain_first = hold_next;
    char_queue.insert(char_queue.size(), entry);
    hold_next = 1'b0;
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endfunction

  // Any byte except NUL and the comment closer
  function automatic logic [CHAR_W-1:0] comment_byte();
    logic [CHAR_W-1:0] b;
    b = CHAR_W'($urandom_range(1, 255));
    if (b == CH_RPAREN) b = CH_LPAREN;
    return b;
  endfunction

  // Blanks and closed comments
  function automatic void queue_blanks(int max_n);
    int n;
    n = $urandom_range(0, max_n);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0, 1: queue_char(CH_SPACE);
        2: queue_char(CH_TAB);
        default: begin
          queue_char(CH_LPAREN);
          repeat ($urandom_range(0, 4)) queue_char(comment_byte());
          queue_char(CH_RPAREN);
        end
      endcase
    end
  endfunction

  function automatic void queue_word();
    int pick;
    int ndig;
    int point_at;
    int sign;
    bit nines;
    pick = $urandom_range(0, 99);
    if (pick < 3) queue_char(CHAR_W'($urandom_range(1, 255)));  // mostly a bad letter
    else if (pick < 50) queue_char(CH_UPPER_A + CHAR_W'($urandom_range(0, 25)));
    else queue_char(CH_LOWER_A + CHAR_W'($urandom_range(0, 25)));
    if ($urandom_range(0, 3) == 0) queue_blanks(2);

    // Digit count: mostly short, some at the limit, a few one past it
    pick = $urandom_range(0, 99);
    if (pick < 4) ndig = 0;
    else if (pick < 12) ndig = MAX_DIGITS_DEF;
    else if (pick < 16) ndig = MAX_DIGITS_DEF + 1;
    else ndig = $urandom_range(1, 6);
    sign = $urandom_range(0, 2);
    if (sign == 1) queue_char(CH_PLUS);
    else if (sign == 2) queue_char(CH_MINUS);
    point_at = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, ndig)) : -1;
    nines = (ndig >= MAX_DIGITS_DEF) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i <= ndig; i++) begin
      if (i == point_at) queue_char(CH_POINT);
      if (i < ndig) queue_char(nines ? CH_NINE : CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 1) == 0) queue_blanks(2);
  endfunction

  function automatic void queue_line();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      // noise line
      repeat ($urandom_range(1, 12)) queue_char(CHAR_W'($urandom_range(1, 255)));
    end else begin
      queue_blanks(1);
      repeat ($urandom_range(0, 6)) queue_word();
    end
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      // program end mark, then junk that must be dropped
      queue_char(CH_PERCENT);
      repeat ($urandom_range(0, 3)) queue_char(CHAR_W'($urandom_range(1, 255)));
    end else if (pick < 5) begin
      // comment left open at the end of the line
      queue_char(CH_LPAREN);
      repeat ($urandom_range(0, 3)) queue_char(comment_byte());
    end
    queue_char(CH_NUL);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present one character per transaction, random gaps between them
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  = 0;
    end else begin
      if (in_tvalid && in_tready) lex_char(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (char_queue.size() == 0 ||
                     (char_queue[0].drain_first && expected_results.size() != 0)) begin
          // nothing left, or hold until every due result has come out
          in_tvalid <= 1'b0;
        end else begin
          next_char = char_queue.pop_front();
          in_tdata  <= next_char.code;
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 12);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall at random, check each result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      take_gap     = 0;
      quiet_cycles = 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;

      if (out_tvalid && out_tready) begin
        got.kind         = out_tuser;
        got.word_letter  = out_tdata[0 +: LETTER_W];
        got.mantissa     = out_tdata[LETTER_W +: MANT_W];
        got.frac_digits  = out_tdata[LETTER_W + MANT_W +: COUNT_W];
        got.start_offset = out_tdata[LETTER_W + MANT_W + COUNT_W +: OFFSET_W];
        got.last         = out_tlast;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result kind %0d letter %0d mantissa %0d", $realtime,
                     got.kind, got.word_letter, got.mantissa);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $write("%0t: mismatch (expected/actual) kind %0d/%0d letter %0d/%0d ",
                     $realtime, want.kind, got.kind, want.word_letter, got.word_letter);
              $display("mantissa %0d/%0d frac %0d/%0d offset %0d/%0d last %0b/%0b",
                       want.mantissa, got.mantissa, want.frac_digits, got.frac_digits,
                       want.start_offset, got.start_offset, want.last, got.last);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
        take_gap = take_calm ? 0 : $urandom_range(0, 12);
      end

      if (take_gap > 0) begin
        take_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int start_size;

    // Directed lines: lower-case fold, sign or point alone, comment between
    // words, second point ending a word, junk after a stop
    queue_text("x-\tY+.(c)Z1.2.%");
    queue_char(CH_NUL);
    queue_text("M%");                // missing value at the end mark
    queue_char(CH_NUL);
    queue_char(8'hFF);               // high byte where a letter belongs
    queue_char(CH_NUL);
    queue_text("G(");                // line ends inside a value comment
    queue_char(CH_NUL);
    queue_char(CH_LPAREN);           // line ends inside a letter comment
    queue_char(CH_NUL);

    // Random lines, entered only once the directed results are out
    hold_next  = 1'b1;
    start_size = char_queue.size();
    while (char_queue.size() - start_size < RANDOM_CHARS / 2) queue_line();

    // Second half, again held until every earlier result is out
    hold_next  = 1'b1;
    start_size = char_queue.size();
    while (char_queue.size() - start_size < RANDOM_CHARS / 2) queue_line();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all characters sent, all predicted results seen, then a short tail
    @(negedge clk);
    while (char_queue.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (expected_results.size() != 0) begin
      $display("%0d predicted results never arrived", expected_results.size());
      mismatch_count += expected_results.size();
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/gwl_pkg.sv
rtl/gwl_lexer.sv
rtl/gwl_res_fifo.sv
rtl/gcode_word_lexer_core.sv
tb/tb_gcode_word_lexer_core.sv
